// File: rtl/gpf_pkg.sv
`default_nettype none
package gpf_pkg;

  // Input beat: two particles, Q16.16
  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_pos_z;
    logic        [31:0] first_mass;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_pos_z;
    logic        [31:0] second_mass;
  } gpf_in_t;

  // Output beat: force on the second particle, signed Q32.16 in 48 bits
  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               too_close;
    logic               saturated;
  } gpf_out_t;

  // Register map, selected by paddr[2]
  typedef enum logic {
    REG_GRAV = 1'b0,
    REG_MIND = 1'b1
  } gpf_reg_t;

  localparam logic [31:0] GRAV_RESET = 32'h0001_0000;
  localparam logic [31:0] MIND_RESET = 32'h0000_0001;

  localparam int MAG_W  = 33;   // |p1 - p2|
  localparam int DSQ_W  = 66;   // sum of squares
  localparam int ROOT_W = 34;   // floor(sqrt)
  localparam int S3_W   = 102;  // root cubed
  localparam int GM_W   = 96;   // G*m1*m2
  localparam int NUM_W  = 129;  // G*m1*m2*|d|
  localparam int Q_W    = 48;   // quotient bits kept

  localparam logic [47:0] FMAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] FMIN48 = 48'h8000_0000_0000;

endpackage
`default_nettype wire

// File: rtl/gravity_pair_force.sv
`default_nettype none
// Pairwise gravitational force, one particle pair per beat.
//
// in_valid/in_stall/in_data carry a pair of particles (Q16.16 positions and
// masses); out_valid/out_stall/out_data return the force on the second
// particle, G*m1*m2*d/|d|^3, saturated to 48 bits, with too_close and
// saturated flags. Negate the vector for the force on the first particle.
//
// Throughput: one pair per cycle while out_stall does not hold the pipeline.
// The depth is set by the square root (one root bit per stage, 34 stages) and
// the divider (one quotient bit per stage, 48 stages), plus difference,
// multiply, root and divider load, and output stages.
//
// The pipeline moves as a whole: while out_valid is high and out_stall is
// high every stage holds and in_stall is raised; no beat is lost or repeated.
// Empty stages are carried as bubbles.
//
// Reset clears every valid bit and loads G = 1.0 and min_distance = 1 LSB.
// The APB-style port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
// G at address 0 and min_distance at address 4; write it only while idle.
module gravity_pair_force (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire gpf_pkg::gpf_in_t in_data,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      gpf_pkg::gpf_out_t out_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output      logic [31:0]      prdata,
  output      logic             pready
);
  import gpf_pkg::*;

  localparam int SQ_N   = ROOT_W;          // root stages
  localparam int SQ_0   = 4;               // first root stage
  localparam int C1     = SQ_0 + SQ_N;     // s*s
  localparam int C2     = C1 + 1;          // partial products
  localparam int C3     = C2 + 1;          // s^3 and numerators
  localparam int C4     = C3 + 1;          // overflow check, divider load
  localparam int DV_0   = C4 + 1;          // first divider stage
  localparam int OST    = DV_0 + Q_W;      // output register
  localparam int NST    = OST + 1;

  // payload carried through the root stages
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [GM_W-1:0]       gm;
    logic                  close;
  } gpf_sqc_t;

  // payload carried through the divider stages
  typedef struct packed {
    logic [S3_W-1:0] s3;
    logic [2:0]      neg;
    logic [2:0]      ovf;
    logic            close;
  } gpf_dvc_t;

  // ---------------- configuration ----------------
  logic [31:0] grav_r, mind_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAV_RESET;
      mind_r <= MIND_RESET;
    end else if (cfg_wr) begin
      case (gpf_reg_t'(paddr[2]))
        REG_GRAV: grav_r <= pwdata;
        REG_MIND: mind_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (gpf_reg_t'(paddr[2]))
      REG_GRAV: prdata = grav_r;
      REG_MIND: prdata = mind_r;
      default:  prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic [NST-1:0] v_r;
  logic           adv;

  assign adv       = !v_r[OST] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = v_r[OST];

  // shift valid bits along with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // ---------------- stage A: differences ----------------
  logic [2:0][MAG_W-1:0] a_mag_r;
  logic [2:0]            a_neg_r;
  logic [31:0]           a_m1_r, a_m2_r;
  logic [2:0][MAG_W-1:0] a_diff;

  always_comb begin
    a_diff[0] = {in_data.first_pos_x[31], in_data.first_pos_x}
              - {in_data.second_pos_x[31], in_data.second_pos_x};
    a_diff[1] = {in_data.first_pos_y[31], in_data.first_pos_y}
              - {in_data.second_pos_y[31], in_data.second_pos_y};
    a_diff[2] = {in_data.first_pos_z[31], in_data.first_pos_z}
              - {in_data.second_pos_z[31], in_data.second_pos_z};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_neg_r[i] <= a_diff[i][MAG_W-1];
        a_mag_r[i] <= a_diff[i][MAG_W-1] ? (~a_diff[i] + 1'b1) : a_diff[i];
      end
      a_m1_r <= in_data.first_mass;
      a_m2_r <= in_data.second_mass;
    end
  end

  // ---------------- stage B: squares, G*m1 ----------------
  logic [2:0][DSQ_W-1:0] b_sq_r;
  logic [63:0]           b_gm1_r;
  logic [2:0][MAG_W-1:0] b_mag_r;
  logic [2:0]            b_neg_r;
  logic [31:0]           b_m2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_r[i] <= DSQ_W'(a_mag_r[i]) * DSQ_W'(a_mag_r[i]);
      end
      b_gm1_r <= 64'(grav_r) * 64'(a_m1_r);
      b_mag_r <= a_mag_r;
      b_neg_r <= a_neg_r;
      b_m2_r  <= a_m2_r;
    end
  end

  // ---------------- stage C: sum, G*m1*m2 halves, limit ----------------
  logic [DSQ_W-1:0]      c_d_r;
  logic [63:0]           c_gml_r, c_gmh_r, c_mdsq_r;
  logic [2:0][MAG_W-1:0] c_mag_r;
  logic [2:0]            c_neg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_d_r    <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      c_gml_r  <= 64'(b_gm1_r[31:0]) * 64'(b_m2_r);
      c_gmh_r  <= 64'(b_gm1_r[63:32]) * 64'(b_m2_r);
      c_mdsq_r <= 64'(mind_r) * 64'(mind_r);
      c_mag_r  <= b_mag_r;
      c_neg_r  <= b_neg_r;
    end
  end

  // ---------------- stage E: too-close test, root load ----------------
  logic [DSQ_W-1:0]  sr_rem_r  [SQ_N+1];
  logic [ROOT_W-1:0] sr_root_r [SQ_N+1];
  gpf_sqc_t          sr_pl_r   [SQ_N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_rem_r[0]      <= c_d_r;
      sr_root_r[0]     <= '0;
      sr_pl_r[0].mag   <= c_mag_r;
      sr_pl_r[0].neg   <= c_neg_r;
      sr_pl_r[0].gm    <= {c_gmh_r, 32'b0} + GM_W'(c_gml_r);
      sr_pl_r[0].close <= (c_d_r == '0) || (c_d_r < DSQ_W'(c_mdsq_r));
    end
  end

  // ---------------- root stages: one bit each, MSB first ----------------
  for (genvar j = 1; j <= SQ_N; j++) begin : g_sqrt
    localparam int B = SQ_N - j;
    logic [DSQ_W+1:0] trial;
    logic             take;

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = ((DSQ_W+2)'(sr_root_r[j-1]) << (B + 1))
                 | ((DSQ_W+2)'(1) << (2 * B));
    assign take  = (DSQ_W+2)'(sr_rem_r[j-1]) >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_rem_r[j]  <= take ? DSQ_W'((DSQ_W+2)'(sr_rem_r[j-1]) - trial)
                             : sr_rem_r[j-1];
        sr_root_r[j] <= sr_root_r[j-1] | (take ? (ROOT_W'(1) << B) : '0);
        sr_pl_r[j]   <= sr_pl_r[j-1];
      end
    end
  end

  // ---------------- C1: s*s ----------------
  logic [67:0]       c1_s2_r;
  logic [ROOT_W-1:0] c1_s_r;
  gpf_sqc_t          c1_pl_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_s2_r <= 68'(sr_root_r[SQ_N]) * 68'(sr_root_r[SQ_N]);
      c1_s_r  <= sr_root_r[SQ_N];
      c1_pl_r <= sr_pl_r[SQ_N];
    end
  end

  // ---------------- C2: partial products ----------------
  logic [67:0]      c2_plo_r, c2_phi_r;
  logic [2:0][64:0] c2_pa_r, c2_pb_r, c2_pc_r;
  logic [2:0]       c2_neg_r;
  logic             c2_close_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_plo_r <= 68'(c1_s2_r[33:0]) * 68'(c1_s_r);
      c2_phi_r <= 68'(c1_s2_r[67:34]) * 68'(c1_s_r);
      for (int i = 0; i < 3; i++) begin
        c2_pa_r[i] <= 65'(c1_pl_r.gm[31:0])  * 65'(c1_pl_r.mag[i]);
        c2_pb_r[i] <= 65'(c1_pl_r.gm[63:32]) * 65'(c1_pl_r.mag[i]);
        c2_pc_r[i] <= 65'(c1_pl_r.gm[95:64]) * 65'(c1_pl_r.mag[i]);
      end
      c2_neg_r   <= c1_pl_r.neg;
      c2_close_r <= c1_pl_r.close;
    end
  end

  // ---------------- C3: s^3, numerators ----------------
  logic [S3_W-1:0]       c3_s3_r;
  logic [2:0][NUM_W-1:0] c3_num_r;
  logic [2:0]            c3_neg_r;
  logic                  c3_close_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_s3_r <= {c2_phi_r, 34'b0} + S3_W'(c2_plo_r);
      for (int i = 0; i < 3; i++) begin
        c3_num_r[i] <= {c2_pc_r[i], 64'b0} + NUM_W'({c2_pb_r[i], 32'b0})
                     + NUM_W'(c2_pa_r[i]);
      end
      c3_neg_r   <= c2_neg_r;
      c3_close_r <= c2_close_r;
    end
  end

  // ---------------- C4: overflow test, divider load ----------------
  logic [2:0][S3_W-1:0] dv_rem_r [Q_W+1];
  logic [2:0][Q_W-1:0]  dv_nlo_r [Q_W+1];
  logic [2:0][Q_W-1:0]  dv_q_r   [Q_W+1];
  gpf_dvc_t             dv_pl_r  [Q_W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // quotient needs more than 48 bits when num >> 48 >= s^3
        dv_pl_r[0].ovf[i] <= S3_W'(c3_num_r[i][NUM_W-1:Q_W]) >= c3_s3_r;
        dv_rem_r[0][i]    <= S3_W'(c3_num_r[i][NUM_W-1:Q_W]);
        dv_nlo_r[0][i]    <= c3_num_r[i][Q_W-1:0];
        dv_q_r[0][i]      <= '0;
      end
      dv_pl_r[0].s3    <= c3_s3_r;
      dv_pl_r[0].neg   <= c3_neg_r;
      dv_pl_r[0].close <= c3_close_r;
    end
  end

  // ---------------- divider stages: one quotient bit each ----------------
  for (genvar j = 1; j <= Q_W; j++) begin : g_div
    logic [2:0][S3_W:0] part;
    logic [2:0]         ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        part[i] = {dv_rem_r[j-1][i], dv_nlo_r[j-1][i][Q_W-1]};
        ge[i]   = part[i] >= {1'b0, dv_pl_r[j-1].s3};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j][i] <= ge[i] ? S3_W'(part[i] - {1'b0, dv_pl_r[j-1].s3})
                                  : S3_W'(part[i]);
          dv_nlo_r[j][i] <= {dv_nlo_r[j-1][i][Q_W-2:0], 1'b0};
          dv_q_r[j][i]   <= {dv_q_r[j-1][i][Q_W-2:0], ge[i]};
        end
        dv_pl_r[j] <= dv_pl_r[j-1];
      end
    end
  end

  // ---------------- output: sign, saturate, too-close ----------------
  gpf_out_t         out_r;
  logic [2:0][47:0] o_res;
  logic [2:0]       o_sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_pl_r[Q_W].neg[i]) begin
        o_sat[i] = dv_pl_r[Q_W].ovf[i] || dv_q_r[Q_W][i][47];
        o_res[i] = o_sat[i] ? FMAX48 : dv_q_r[Q_W][i];
      end else begin
        o_sat[i] = dv_pl_r[Q_W].ovf[i]
                || (dv_q_r[Q_W][i][47] && (dv_q_r[Q_W][i][46:0] != '0));
        o_res[i] = o_sat[i] ? FMIN48 : (~dv_q_r[Q_W][i] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv_pl_r[Q_W].close) begin
        out_r.force_x   <= '0;
        out_r.force_y   <= '0;
        out_r.force_z   <= '0;
        out_r.too_close <= 1'b1;
        out_r.saturated <= 1'b0;
      end else begin
        out_r.force_x   <= o_res[0];
        out_r.force_y   <= o_res[1];
        out_r.force_z   <= o_res[2];
        out_r.too_close <= 1'b0;
        out_r.saturated <= |o_sat;
      end
    end
  end

  assign out_data = out_r;

  // ---------------- assertions ----------------
  a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.too_close |->
      out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0)
    else $error("too_close beat carries a nonzero force");

  a_close_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.too_close |-> !out_data.saturated)
    else $error("too_close and saturated both set");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.force_x == FMAX48 || out_data.force_x == FMIN48 ||
      out_data.force_y == FMAX48 || out_data.force_y == FMIN48 ||
      out_data.force_z == FMAX48 || out_data.force_z == FMIN48)
    else $error("saturated set but no component at a limit");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted beat did not enter the first stage");

endmodule
`default_nettype wire
